// ===== hdl/mtg_pkg.sv =====
package mtg_pkg;

   localparam int STORE_DEPTH  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int ADDR_WIDTH   = 10;
   localparam int WORD_WIDTH   = 32;

   localparam logic [WORD_WIDTH-1:0] TOP_BIT_MASK  = 32'h8000_0000;
   localparam logic [WORD_WIDTH-1:0] LOW_BITS_MASK = 32'h7FFF_FFFF;
   localparam logic [WORD_WIDTH-1:0] TWIST_MATRIX  = 32'h9908_B0DF;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      logic load_write;
      logic pos_clear;
      logic pos_incr;
      logic prime_read;
      logic regen_init;
      logic regen_step;
      logic regen_write;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic pos_exhausted;
      logic regen_first;
      logic regen_last;
      logic out_free;
   } status_type;

   function automatic word_type twist_word(word_type upper_src, word_type lower_src,
                                           word_type far_word);
      word_type joined;
      word_type mixed;
      joined = (upper_src & TOP_BIT_MASK) | (lower_src & LOW_BITS_MASK);
      mixed  = joined >> 1;
      if (joined[0]) begin
         mixed = mixed ^ TWIST_MATRIX;
      end
      return far_word ^ mixed;
   endfunction

endpackage

// ===== hdl/mersenne_twister_generator.sv =====
// Channel   Ports                                         Transfer when
// req       req_mode, req_load_index, req_load_word       req_valid && req_ready
// rsp       rsp_random_word                               rsp_valid && rsp_ready
//
// A load transfer writes the store in the cycle it is accepted; an index past the store is not written.
// A draw steps through accept, store read and output register load, in that order.
// A draw at the end of the store first regenerates it, one word per cycle through
// the two-read-port store.
// Reset clears the read position and the output valid flag; the store and the output word are not cleared.
// A waiting result holds only a draw in its last cycle; loads are taken meanwhile.
module mersenne_twister_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  mtg_pkg::addr_type req_load_index,
   input  mtg_pkg::word_type req_load_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtg_pkg::word_type rsp_random_word
);
   import mtg_pkg::*;

   cmd_type    cmd;
   status_type status;

   mtg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mtg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_load_index  (req_load_index),
      .req_load_word   (req_load_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_word (rsp_random_word),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ===== hdl/mtg_controller.sv =====
module mtg_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_ready,
   input  mtg_pkg::status_type  status,
   output mtg_pkg::cmd_type     cmd
);
   import mtg_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_PRIME   = 3'd1;
   localparam logic [2:0] ST_REGEN   = 3'd2;
   localparam logic [2:0] ST_DRAIN   = 3'd3;
   localparam logic [2:0] ST_FETCH   = 3'd4;
   localparam logic [2:0] ST_DELIVER = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_LOAD) begin
                  cmd.load_write = 1'b1;
                  cmd.pos_clear  = 1'b1;
               end else if (status.pos_exhausted) begin
                  state_in = ST_PRIME;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_PRIME: begin
            cmd.prime_read = 1'b1;
            cmd.regen_init = 1'b1;
            state_in       = ST_REGEN;
         end
         ST_REGEN: begin
            cmd.regen_step  = 1'b1;
            cmd.regen_write = !status.regen_first;
            if (status.regen_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.regen_write = 1'b1;
            cmd.pos_clear   = 1'b1;
            state_in        = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.pos_incr = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/mtg_datapath.sv =====
module mtg_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mtg_pkg::addr_type    req_load_index,
   input  mtg_pkg::word_type    req_load_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mtg_pkg::word_type    rsp_random_word,
   input  mtg_pkg::cmd_type     cmd,
   output mtg_pkg::status_type  status
);
   import mtg_pkg::*;

   localparam addr_type LAST_ADDR = addr_type'(STORE_DEPTH - 1);
   localparam addr_type FAR_WRAP  = addr_type'(STORE_DEPTH - TWIST_OFFSET);
   localparam addr_type FAR_STEP  = addr_type'(TWIST_OFFSET);
   localparam addr_type DEPTH_A   = addr_type'(STORE_DEPTH);

   word_type store_mem [STORE_DEPTH];

   addr_type pos_ff;
   addr_type pos_in;
   addr_type k_ff;
   addr_type k_in;
   word_type upper_ff;
   word_type rd_a_ff;
   word_type rd_b_ff;
   word_type rsp_word_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;

   addr_type next_addr;
   addr_type far_addr;
   addr_type rd_a_addr;
   addr_type wr_addr;
   word_type wr_data;
   logic     wr_en;

   assign next_addr = (k_ff == LAST_ADDR) ? '0 : k_ff + addr_type'(1);
   assign far_addr  = (k_ff < FAR_WRAP) ? k_ff + FAR_STEP : k_ff - FAR_WRAP;

   always_comb begin
      priority if (cmd.regen_step) begin
         rd_a_addr = next_addr;
      end else if (cmd.prime_read) begin
         rd_a_addr = '0;
      end else begin
         rd_a_addr = pos_ff;
      end
   end

   always_comb begin
      if (cmd.load_write) begin
         wr_en   = (req_load_index < DEPTH_A);
         wr_addr = req_load_index;
         wr_data = req_load_word;
      end else begin
         wr_en   = cmd.regen_write;
         wr_addr = k_ff - addr_type'(1);
         wr_data = twist_word(upper_ff, rd_a_ff, rd_b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_mem[rd_a_addr];
      rd_b_ff <= store_mem[far_addr];
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_clear) begin
         pos_in = '0;
      end else if (cmd.pos_incr) begin
         pos_in = pos_ff + addr_type'(1);
      end
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.regen_init) begin
         k_in = '0;
      end else if (cmd.regen_step) begin
         k_in = k_ff + addr_type'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.regen_step) begin
         upper_ff <= rd_a_ff;
      end
      if (cmd.rsp_load) begin
         rsp_word_ff <= rd_a_ff;
      end
   end

   assign status.pos_exhausted = (pos_ff >= DEPTH_A);
   assign status.regen_first   = (k_ff == '0);
   assign status.regen_last    = (k_ff == LAST_ADDR);
   assign status.out_free      = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

endmodule

// ===== hdl/mtg_checker.sv =====
module mtg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_mode,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mtg_pkg::word_type rsp_random_word
);
   import mtg_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_word))
      else $error("stalled result changed");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load transfer produced a result");

   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_DRAW |=> !req_ready)
      else $error("input ready while a draw is in progress");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_random_word (rsp_random_word)
);
